### hdl/abs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types, codes and helpers of the block acquisition sequencer.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int DEF_BUFFER_COUNT      = 4;
  localparam int DEF_MAX_BLOCK_SAMPLES = 1024 * 8;

  localparam int REQ_W    = 3;
  localparam int COUNT_W  = 32;
  localparam int BUF_W    = 2;
  localparam int TIME_W   = 64;
  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 3;
  localparam int SAMP_W   = 14;
  localparam int MASK_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int BITS_PER_SAMPLE = 12;
  localparam int BYTE_ROUND      = 8 - 1;

  localparam logic [MASK_W-1:0] RST_CHANNEL_MASK  = 5'd1;
  localparam logic [SAMP_W-1:0] RST_BLOCK_SAMPLES = 14'd1000;
  localparam logic              RST_TRIGGER_EN    = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 3'd0,
    REQ_STOP    = 3'd1,
    REQ_TRIGGER = 3'd2,
    REQ_DONE    = 3'd3,
    REQ_RELEASE = 3'd4
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    RES_START  = 2'd0,
    RES_REPORT = 2'd1,
    RES_STOP   = 2'd2
  } res_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_MASK   = 2'd0,
    CFG_BLOCK_SAMPLES  = 2'd1,
    CFG_TRIGGER_ENABLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [COUNT_W-1:0] blocks_requested;
    logic               infinite_mode;
    logic [BUF_W-1:0]   released_buffer;
    logic [TIME_W-1:0]  timestamp_us;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [BUF_W-1:0]   buffer_index;
    logic [CHAN_W-1:0]  first_channel;
    logic [SAMP_W-1:0]  sample_count;
    logic [SAMP_W-1:0]  payload_bytes;
    logic [MASK_W-1:0]  report_mask;
    logic [COUNT_W-1:0] blocks_remaining;
    logic               delayed_by_buffer;
    logic [TIME_W-1:0]  blk_start_us;
    logic [TIME_W-1:0]  blk_end_us;
    logic               last;
  } result_t;

  // Up to two results handed from the core to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Lowest set bit of the mask; MASK_W when the mask is empty.
  function automatic logic [CHAN_W-1:0] lowest_channel(input logic [MASK_W-1:0] mask);
    logic [CHAN_W-1:0] ch;
    ch = CHAN_W'(MASK_W);
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        ch = CHAN_W'(i);
      end
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

### hdl/abs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_if
// Valid/ready channels of the sequencer: request, result and register write.
// ----------------------------------------------------------------------------
interface abs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] blocks_requested;
  logic        infinite_mode;
  logic [1:0]  released_buffer;
  logic [63:0] timestamp_us;

  modport source (output valid, req_type, blocks_requested, infinite_mode,
                  released_buffer, timestamp_us, input ready);
  modport sink   (input valid, req_type, blocks_requested, infinite_mode,
                  released_buffer, timestamp_us, output ready);
endinterface

interface abs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  buffer_index;
  logic [2:0]  first_channel;
  logic [13:0] sample_count;
  logic [13:0] payload_bytes;
  logic [4:0]  report_mask;
  logic [31:0] blocks_remaining;
  logic        delayed_by_buffer;
  logic [63:0] blk_start_us;
  logic [63:0] blk_end_us;
  logic        last;

  modport source (output valid, result_kind, buffer_index, first_channel, sample_count,
                  payload_bytes, report_mask, blocks_remaining, delayed_by_buffer,
                  blk_start_us, blk_end_us, last, input ready);
  modport sink   (input valid, result_kind, buffer_index, first_channel, sample_count,
                  payload_bytes, report_mask, blocks_remaining, delayed_by_buffer,
                  blk_start_us, blk_end_us, last, output ready);
endinterface

interface abs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/abs_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_core
// Request register, config registers and sequencer state; while the queue has
// room, one request is resolved per cycle into up to two result records.
// ----------------------------------------------------------------------------
module abs_core #(
  parameter int BUFFER_COUNT      = abs_pkg::DEF_BUFFER_COUNT,
  parameter int MAX_BLOCK_SAMPLES = abs_pkg::DEF_MAX_BLOCK_SAMPLES
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  abs_req_if.sink      req_ch,
  abs_cfg_if.sink      cfg_ch,
  input  wire logic    room_i,
  output abs_pkg::push_t push_o
);
  import abs_pkg::*;

  localparam int AW  = $clog2(BUFFER_COUNT);
  localparam int SW  = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int NW  = (SW > SAMP_W) ? SW : SAMP_W;
  localparam int PW  = NW + 4;

  // configuration
  logic [MASK_W-1:0] chan_mask_q;
  logic [SAMP_W-1:0] blk_samples_q;
  logic              trig_en_q;

  // request register
  logic req_valid_q;
  req_t req_q;
  logic process;

  // sequencer state
  logic [COUNT_W-1:0]    blocks_left_q, blocks_left_d;
  logic                  run_forever_q, run_forever_d;
  logic                  armed_q, armed_d;
  logic                  waiting_q, waiting_d;
  logic                  delayed_q, delayed_d;
  logic                  sampling_q, sampling_d;
  logic [AW-1:0]         active_q, active_d;
  logic [BUFFER_COUNT-1:0] locked_q, locked_d;
  logic [TIME_W-1:0]     start_time_q, start_time_d;

  logic [NW-1:0]     n_clamp;
  logic [PW-1:0]     bytes_w;
  result_t           base_rec;
  result_t           rep_rec;
  logic [1:0]        cnt;
  logic              sched, try_start, begin_blk, report;
  logic [AW-1:0]     prev_buf;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_mask_q   <= RST_CHANNEL_MASK;
      blk_samples_q <= RST_BLOCK_SAMPLES;
      trig_en_q     <= RST_TRIGGER_EN;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_CHANNEL_MASK:   chan_mask_q   <= cfg_ch.data[MASK_W-1:0];
        CFG_BLOCK_SAMPLES:  blk_samples_q <= cfg_ch.data;
        CFG_TRIGGER_ENABLE: trig_en_q     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign process      = req_valid_q && room_i;
  assign req_ch.ready = !req_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ch.ready) begin
      req_valid_q <= req_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ch.ready && req_ch.valid) begin
      req_q.req_type         <= req_ch.req_type;
      req_q.blocks_requested <= req_ch.blocks_requested;
      req_q.infinite_mode    <= req_ch.infinite_mode;
      req_q.released_buffer  <= req_ch.released_buffer;
      req_q.timestamp_us     <= req_ch.timestamp_us;
    end
  end

  // block size, clamped, and packed byte count
  always_comb begin
    n_clamp = NW'(blk_samples_q);
    if (blk_samples_q == '0) begin
      n_clamp = NW'(1);
    end else if (n_clamp > NW'(MAX_BLOCK_SAMPLES)) begin
      n_clamp = NW'(MAX_BLOCK_SAMPLES);
    end
    bytes_w = (PW'(n_clamp) * PW'(BITS_PER_SAMPLE) + PW'(BYTE_ROUND)) >> 3;
  end

  always_comb begin
    blocks_left_d = blocks_left_q;
    run_forever_d = run_forever_q;
    armed_d       = armed_q;
    waiting_d     = waiting_q;
    delayed_d     = delayed_q;
    sampling_d    = sampling_q;
    active_d      = active_q;
    locked_d      = locked_q;
    start_time_d  = start_time_q;
    sched         = 1'b0;
    try_start     = 1'b0;
    begin_blk     = 1'b0;
    report        = 1'b0;
    prev_buf      = active_q;
    cnt           = 2'd0;

    base_rec.result_kind       = RES_START;
    base_rec.buffer_index      = '0;
    base_rec.first_channel     = lowest_channel(chan_mask_q);
    base_rec.sample_count      = n_clamp[SAMP_W-1:0];
    base_rec.payload_bytes     = bytes_w[SAMP_W-1:0];
    base_rec.report_mask       = chan_mask_q;
    base_rec.blocks_remaining  = blocks_left_q;
    base_rec.delayed_by_buffer = 1'b0;
    base_rec.blk_start_us      = '0;
    base_rec.blk_end_us        = '0;
    base_rec.last              = 1'b0;
    push_o.r0 = base_rec;
    push_o.r1 = base_rec;
    rep_rec   = base_rec;

    if (process) begin
      case (req_q.req_type)
        REQ_START: begin
          if (blocks_left_q == '0 && !run_forever_q) begin
            blocks_left_d = req_q.blocks_requested;
            run_forever_d = req_q.infinite_mode;
            sched         = 1'b1;
          end
        end
        REQ_STOP: begin
          push_o.r0.result_kind   = RES_STOP;
          push_o.r0.first_channel = '0;
          push_o.r0.sample_count  = '0;
          push_o.r0.payload_bytes = '0;
          push_o.r0.report_mask   = '0;
          cnt           = 2'd1;
          run_forever_d = 1'b0;
          blocks_left_d = '0;
          waiting_d     = 1'b0;
          armed_d       = 1'b0;
        end
        REQ_TRIGGER: begin
          try_start = armed_q;
        end
        REQ_DONE: begin
          if (sampling_q) begin
            sampling_d = 1'b0;
            active_d   = (active_q == AW'(BUFFER_COUNT - 1)) ? '0 : active_q + AW'(1);
            if (blocks_left_q != '0) begin
              blocks_left_d = blocks_left_q - COUNT_W'(1);
            end
            sched  = 1'b1;
            report = 1'b1;
          end
        end
        REQ_RELEASE: begin
          if (32'(req_q.released_buffer) < BUFFER_COUNT) begin
            locked_d[AW'(req_q.released_buffer)] = 1'b0;
          end
          begin_blk = waiting_q && !locked_d[active_d];
        end
        default: ;
      endcase

      if (sched && (run_forever_d || blocks_left_d != '0)) begin
        if (trig_en_q) begin
          armed_d = 1'b1;
        end else begin
          try_start = 1'b1;
        end
      end

      if (try_start) begin
        armed_d = 1'b0;
        if (locked_d[active_d]) begin
          waiting_d = 1'b1;
        end else begin
          begin_blk = 1'b1;
        end
      end

      if (begin_blk) begin
        delayed_d             = waiting_d;
        waiting_d             = 1'b0;
        start_time_d          = req_q.timestamp_us;
        locked_d[active_d]    = 1'b1;
        sampling_d            = 1'b1;
        push_o.r0.result_kind       = RES_START;
        push_o.r0.buffer_index      = BUF_W'(active_d);
        push_o.r0.blocks_remaining  = blocks_left_d;
        push_o.r0.delayed_by_buffer = delayed_d;
        push_o.r0.blk_start_us      = req_q.timestamp_us;
        cnt = 2'd1;
      end

      // the report of the finished block follows any block start
      if (report) begin
        rep_rec.result_kind       = RES_REPORT;
        rep_rec.buffer_index      = BUF_W'(prev_buf);
        rep_rec.blocks_remaining  = blocks_left_d;
        rep_rec.delayed_by_buffer = delayed_q;
        rep_rec.blk_start_us      = start_time_q;
        rep_rec.blk_end_us        = req_q.timestamp_us;
        if (cnt == 2'd0) begin
          push_o.r0 = rep_rec;
        end else begin
          push_o.r1 = rep_rec;
        end
        cnt = cnt + 2'd1;
      end
    end

    push_o.r0.last = (cnt == 2'd1);
    push_o.r1.last = 1'b1;
    push_o.cnt     = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_left_q <= '0;
      run_forever_q <= 1'b0;
      armed_q       <= 1'b0;
      waiting_q     <= 1'b0;
      delayed_q     <= 1'b0;
      sampling_q    <= 1'b0;
      active_q      <= '0;
      locked_q      <= '0;
      start_time_q  <= '0;
    end else begin
      blocks_left_q <= blocks_left_d;
      run_forever_q <= run_forever_d;
      armed_q       <= armed_d;
      waiting_q     <= waiting_d;
      delayed_q     <= delayed_d;
      sampling_q    <= sampling_d;
      active_q      <= active_d;
      locked_q      <= locked_d;
      start_time_q  <= start_time_d;
    end
  end

endmodule
`default_nettype wire

### hdl/abs_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_out_queue
// Two-entry result queue; takes up to two records a cycle, shows one.
// ----------------------------------------------------------------------------
module abs_out_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire abs_pkg::push_t push_i,
  output logic               room_o,
  abs_res_if.source          res_ch
);
  import abs_pkg::*;

  result_t    ent_q [2];
  result_t    ent_d [2];
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop    = res_ch.valid && res_ch.ready;
  // room for two records once this cycle's transfer has left
  assign room_o = (count_q == 2'd0) || (count_q == 2'd1 && pop);

  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    count_d  = count_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      count_d  = count_q - 2'd1;
    end
    if (push_i.cnt != 2'd0) begin
      if (count_d == 2'd0) begin
        ent_d[0] = push_i.r0;
        ent_d[1] = push_i.r1;
      end else begin
        ent_d[1] = push_i.r0;
      end
      count_d = count_d + push_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  assign res_ch.valid             = (count_q != 2'd0);
  assign res_ch.result_kind       = ent_q[0].result_kind;
  assign res_ch.buffer_index      = ent_q[0].buffer_index;
  assign res_ch.first_channel     = ent_q[0].first_channel;
  assign res_ch.sample_count      = ent_q[0].sample_count;
  assign res_ch.payload_bytes     = ent_q[0].payload_bytes;
  assign res_ch.report_mask       = ent_q[0].report_mask;
  assign res_ch.blocks_remaining  = ent_q[0].blocks_remaining;
  assign res_ch.delayed_by_buffer = ent_q[0].delayed_by_buffer;
  assign res_ch.blk_start_us      = ent_q[0].blk_start_us;
  assign res_ch.blk_end_us        = ent_q[0].blk_end_us;
  assign res_ch.last              = ent_q[0].last;

endmodule
`default_nettype wire

### hdl/adc_block_acquisition_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_block_acquisition_sequencer
// Sequences block-wise acquisition into a ring of lockable buffers and emits
// block-start, block-report and stop-report records.
// ----------------------------------------------------------------------------
//  channel  dir  role
//  req_ch   in   events: start, stop, trigger, block done, buffer released
//  res_ch   out  result records, last marks the final one of an event
//  cfg_ch   in   register writes: channel mask, block size, trigger enable
//
// An event sits in the request register and is resolved there in a
// single pass; its records land in a two-entry output queue. One event a cycle
// is sustained while the sink keeps up; a block done that both reports and
// starts the next block gives two records and holds the next event back.
// Reset clears all state and the queue; register writes always complete.
// ----------------------------------------------------------------------------
module adc_block_acquisition_sequencer #(
  parameter int BUFFER_COUNT      = abs_pkg::DEF_BUFFER_COUNT,
  parameter int MAX_BLOCK_SAMPLES = abs_pkg::DEF_MAX_BLOCK_SAMPLES
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  abs_req_if.sink   req_ch,
  abs_res_if.source res_ch,
  abs_cfg_if.sink   cfg_ch
);
  import abs_pkg::*;

  push_t push;  // records resolved this cycle
  logic  room;  // queue can take two records

  abs_core #(
    .BUFFER_COUNT     (BUFFER_COUNT),
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_ch(req_ch),
    .cfg_ch(cfg_ch),
    .room_i(room),
    .push_o(push)
  );

  abs_out_queue u_out_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .room_o(room),
    .res_ch(res_ch)
  );

endmodule
`default_nettype wire

### test/abs_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_sequencer_checker
// Watches the request, result and register channels of the acquisition
// sequencer, works out the records each accepted event should give and
// compares every result transfer against the oldest record still due.
// ----------------------------------------------------------------------------
module abs_sequencer_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  abs_req_if                req_ch,
  abs_res_if                res_ch,
  abs_cfg_if                cfg_ch,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  import abs_pkg::*;

  localparam int NBUF        = DEF_BUFFER_COUNT;
  localparam int MAX_SAMPLES = DEF_MAX_BLOCK_SAMPLES;

  // register copies
  logic [MASK_W-1:0]  mask_r;
  logic [SAMP_W-1:0]  samples_r;
  logic               trig_en_r;

  // sequencer state
  logic [COUNT_W-1:0] blocks_left;
  logic               run_forever;
  logic               armed;
  logic               waiting;
  logic               late_flag;
  logic               sampling;
  logic [BUF_W-1:0]   fill_buf;
  logic [NBUF-1:0]    locked;
  logic [TIME_W-1:0]  t_begin;

  result_t            due_records[$];
  result_t            fresh[$];
  int unsigned        errors = 0;

  function automatic logic [CHAN_W-1:0] first_enabled(input logic [MASK_W-1:0] m);
    int ch;
    ch = 0;
    while (ch < MASK_W && !m[ch]) ch++;
    return CHAN_W'(ch);
  endfunction

  // Block size is clamped and read when the record is made.
  function automatic result_t make_record(input res_kind_e kind, input logic [BUF_W-1:0] slot,
                                          input logic late, input logic [TIME_W-1:0] t0,
                                          input logic [TIME_W-1:0] t1);
    result_t r;
    int      n;
    n = int'(samples_r);
    if (n < 1) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    r                   = '0;
    r.result_kind       = kind;
    r.buffer_index      = slot;
    r.first_channel     = first_enabled(mask_r);
    r.sample_count      = SAMP_W'(n);
    r.payload_bytes     = SAMP_W'((n * BITS_PER_SAMPLE + BYTE_ROUND) / 8);
    r.report_mask       = mask_r;
    r.blocks_remaining  = blocks_left;
    r.delayed_by_buffer = late;
    r.blk_start_us      = t0;
    r.blk_end_us        = t1;
    return r;
  endfunction

  task automatic begin_block(input logic [TIME_W-1:0] ts);
    late_flag        = waiting;
    waiting          = 1'b0;
    t_begin          = ts;
    locked[fill_buf] = 1'b1;
    sampling         = 1'b1;
    fresh.push_back(make_record(RES_START, fill_buf, late_flag, ts, '0));
  endtask

  task automatic start_or_hold(input logic [TIME_W-1:0] ts);
    armed = 1'b0;
    if (locked[fill_buf]) begin
      waiting = 1'b1;
    end else begin
      begin_block(ts);
    end
  endtask

  task automatic schedule_next(input logic [TIME_W-1:0] ts);
    if (run_forever || blocks_left != '0) begin
      if (trig_en_r) begin
        armed = 1'b1;
      end else begin
        start_or_hold(ts);
      end
    end
  endtask

  // Applies one accepted event and queues the records it causes.
  task automatic advance_sequencer();
    logic [TIME_W-1:0] ts;
    logic [BUF_W-1:0]  prev;
    logic              prev_late;
    logic [TIME_W-1:0] t0;
    result_t           r;
    ts = req_ch.timestamp_us;
    fresh.delete();
    case (req_ch.req_type)
      REQ_START: begin
        if (blocks_left == '0 && !run_forever) begin
          blocks_left = req_ch.blocks_requested;
          run_forever = req_ch.infinite_mode;
          schedule_next(ts);
        end
      end
      REQ_STOP: begin
        r               = make_record(RES_STOP, '0, 1'b0, '0, '0);
        r.first_channel = '0;
        r.sample_count  = '0;
        r.payload_bytes = '0;
        r.report_mask   = '0;
        fresh.push_back(r);
        run_forever = 1'b0;
        blocks_left = '0;
        waiting     = 1'b0;
        armed       = 1'b0;
      end
      REQ_TRIGGER: begin
        if (armed) start_or_hold(ts);
      end
      REQ_DONE: begin
        if (sampling) begin
          prev      = fill_buf;
          prev_late = late_flag;
          t0        = t_begin;
          sampling  = 1'b0;
          fill_buf  = BUF_W'((int'(prev) + 1) % NBUF);
          if (blocks_left != '0) blocks_left--;
          // a block started here goes out ahead of the report
          schedule_next(ts);
          fresh.push_back(make_record(RES_REPORT, prev, prev_late, t0, ts));
        end
      end
      REQ_RELEASE: begin
        if (int'(req_ch.released_buffer) < NBUF) locked[req_ch.released_buffer] = 1'b0;
        if (waiting && !locked[fill_buf]) begin_block(ts);
      end
      default: ;
    endcase
    if (fresh.size() != 0) begin
      r      = fresh.pop_back();
      r.last = 1'b1;
      fresh.push_back(r);
    end
    foreach (fresh[i]) due_records.push_back(fresh[i]);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_record();
    result_t want;
    if (due_records.size() == 0) begin
      $display("%0t: result_kind expected none, got %0h", $time, res_ch.result_kind);
      errors++;
      return;
    end
    want = due_records.pop_front();
    check_field("result_kind", 64'(want.result_kind), 64'(res_ch.result_kind));
    check_field("buffer_index", 64'(want.buffer_index), 64'(res_ch.buffer_index));
    check_field("first_channel", 64'(want.first_channel), 64'(res_ch.first_channel));
    check_field("sample_count", 64'(want.sample_count), 64'(res_ch.sample_count));
    check_field("payload_bytes", 64'(want.payload_bytes), 64'(res_ch.payload_bytes));
    check_field("report_mask", 64'(want.report_mask), 64'(res_ch.report_mask));
    check_field("blocks_remaining", 64'(want.blocks_remaining), 64'(res_ch.blocks_remaining));
    check_field("delayed_by_buffer", 64'(want.delayed_by_buffer),
                64'(res_ch.delayed_by_buffer));
    check_field("blk_start_us", want.blk_start_us, res_ch.blk_start_us);
    check_field("blk_end_us", want.blk_end_us, res_ch.blk_end_us);
    check_field("last", 64'(want.last), 64'(res_ch.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_r      = RST_CHANNEL_MASK;
      samples_r   = RST_BLOCK_SAMPLES;
      trig_en_r   = RST_TRIGGER_EN;
      blocks_left = '0;
      run_forever = 1'b0;
      armed       = 1'b0;
      waiting     = 1'b0;
      late_flag   = 1'b0;
      sampling    = 1'b0;
      fill_buf    = '0;
      locked      = '0;
      t_begin     = '0;
      due_records.delete();
    end else begin
      // results first: a record can never leave in the cycle its event arrives
      if (res_ch.valid && res_ch.ready) check_record();
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_CHANNEL_MASK:   mask_r    = cfg_ch.data[MASK_W-1:0];
          CFG_BLOCK_SAMPLES:  samples_r = cfg_ch.data[SAMP_W-1:0];
          CFG_TRIGGER_ENABLE: trig_en_r = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) advance_sequencer();
    end
    mismatches  <= errors;
    outstanding <= due_records.size();
  end

endmodule

### test/adc_block_acquisition_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_block_acquisition_sequencer_test
// Drives events and register writes into the acquisition sequencer with
// random idling on both channels; the checker beside the block predicts and
// compares every record, and this module gives the verdict.
// ----------------------------------------------------------------------------
module adc_block_acquisition_sequencer_test;
  import abs_pkg::*;

  localparam int NBUF            = DEF_BUFFER_COUNT;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 100;
  // events sit in the request register, then the two-entry queue
  localparam int SETTLE_CYCLES   = 8;

  logic        clk_i;
  logic        rst_ni;

  abs_req_if   req_ch ();
  abs_res_if   res_ch ();
  abs_cfg_if   cfg_ch ();

  int unsigned mismatches;
  int unsigned outstanding;

  logic [TIME_W-1:0] now_us = '0;
  int unsigned       sent   = 0;
  bit                quiet  = 1'b0;   // no idling at all in the closing phase
  bit                calm   = 1'b0;   // a phase without idling
  bit                trig_on = 1'b0;  // trigger_enable as last programmed

  adc_block_acquisition_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_ch (req_ch),
    .res_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  abs_sequencer_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_ch      (req_ch),
    .res_ch      (res_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Generous ceiling on the simulation time.
  initial begin
    #5_000_000;
    $display("adc_block_acquisition_sequencer: mismatch");
    $finish;
  end

  // Result sink: stalls in random bursts, one assignment per edge.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Event times mostly run forward; now and then a jump to anywhere.
  function automatic logic [TIME_W-1:0] stamp();
    if ($urandom_range(0, 19) == 0) begin
      now_us = {$urandom, $urandom};
    end else begin
      now_us = now_us + TIME_W'($urandom_range(1, 5000));
    end
    return now_us;
  endfunction

  // One event transfer. Valid is left high so back-to-back events need no
  // second assignment in the same step.
  task automatic send_event(input logic [REQ_W-1:0] kind, input logic [COUNT_W-1:0] count,
                            input logic inf, input logic [BUF_W-1:0] slot,
                            input logic [TIME_W-1:0] ts);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= kind;
    req_ch.blocks_requested <= count;
    req_ch.infinite_mode    <= inf;
    req_ch.released_buffer  <= slot;
    req_ch.timestamp_us     <= ts;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
  endtask

  // Pause the sender until every record is back, then let events that give
  // no record clear the pipeline.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Writes all three registers; unused upper data bits carry noise.
  task automatic program_regs(input logic [MASK_W-1:0] mask, input logic [SAMP_W-1:0] samples,
                              input logic trig);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    write_reg(CFG_CHANNEL_MASK, {noise[CFG_DATA_W-1:MASK_W], mask});
    write_reg(CFG_BLOCK_SAMPLES, samples);
    noise = CFG_DATA_W'($urandom);
    write_reg(CFG_TRIGGER_ENABLE, {noise[CFG_DATA_W-1:1], trig});
    cfg_ch.valid <= 1'b0;
    trig_on = trig;
  endtask

  task automatic noise_event();
    send_event(REQ_W'($urandom), $urandom, 1'($urandom), BUF_W'($urandom), stamp());
  endtask

  // A well-formed run: start, then rounds of trigger / block done / release,
  // usually closed by a stop. Unused fields carry random content.
  task automatic run_session();
    logic [COUNT_W-1:0] count;
    logic               inf;
    int                 rounds;
    inf   = ($urandom_range(0, 7) == 0);
    count = ($urandom_range(0, 9) == 0) ? $urandom : COUNT_W'($urandom_range(0, 6));
    send_event(REQ_START, count, inf, BUF_W'($urandom), stamp());
    rounds = $urandom_range(1, 8);
    repeat (rounds) begin
      if (trig_on && $urandom_range(0, 5) != 0) begin
        send_event(REQ_TRIGGER, $urandom, 1'($urandom), BUF_W'($urandom), stamp());
      end
      send_event(REQ_DONE, $urandom, 1'($urandom), BUF_W'($urandom), stamp());
      if ($urandom_range(0, 2) != 0) begin
        send_event(REQ_RELEASE, $urandom, 1'($urandom), BUF_W'($urandom_range(0, NBUF - 1)),
                   stamp());
      end
    end
    if (inf || $urandom_range(0, 1) == 0) begin
      send_event(REQ_STOP, $urandom, 1'($urandom), BUF_W'($urandom), stamp());
    end
  endtask

  initial begin
    int unsigned phase_end;

    // every input known from time zero
    rst_ni                  <= 1'b0;
    req_ch.valid            <= 1'b0;
    req_ch.req_type         <= REQ_START;
    req_ch.blocks_requested <= '0;
    req_ch.infinite_mode    <= 1'b0;
    req_ch.released_buffer  <= '0;
    req_ch.timestamp_us     <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= CFG_CHANNEL_MASK;
    cfg_ch.data             <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part, reset register values ----
    // nothing running: block done and trigger are dropped, stop still reports
    send_event(REQ_DONE, '0, 1'b0, '0, '0);
    send_event(REQ_TRIGGER, '1, 1'b1, '1, stamp());
    send_event(REQ_STOP, '0, 1'b0, '0, stamp());
    // undefined event codes are dropped
    send_event(REQ_RELEASE + REQ_W'(1), '1, 1'b1, '1, stamp());
    send_event(REQ_RELEASE + REQ_W'(3), '0, 1'b0, '0, stamp());
    // zero-block start is taken but schedules nothing
    send_event(REQ_START, '0, 1'b0, '0, stamp());
    send_event(REQ_START, COUNT_W'(5), 1'b0, '0, '0);
    // start while busy is dropped
    send_event(REQ_START, '1, 1'b1, '0, stamp());
    // four blocks done without releases: the fifth finds its buffer locked
    repeat (4) send_event(REQ_DONE, '0, 1'b0, '0, stamp());
    // release of another buffer does not wake the waiting block
    send_event(REQ_RELEASE, '0, 1'b0, BUF_W'(2), stamp());
    send_event(REQ_RELEASE, '0, 1'b0, BUF_W'(0), '1);
    // report carries the delayed flag of the finished block
    send_event(REQ_DONE, '0, 1'b0, '0, stamp());
    // infinite run straight into a locked buffer, then freed
    send_event(REQ_START, '1, 1'b1, '0, stamp());
    send_event(REQ_RELEASE, '0, 1'b0, BUF_W'(1), stamp());
    // release of the buffer now filling just unlocks it
    send_event(REQ_RELEASE, '0, 1'b0, BUF_W'(1), stamp());
    // stop mid-block: a block still sampling does not make the start busy
    send_event(REQ_STOP, '1, 1'b1, '1, stamp());
    send_event(REQ_START, COUNT_W'(2), 1'b0, '0, stamp());
    send_event(REQ_DONE, '0, 1'b0, '0, stamp());
    send_event(REQ_DONE, '0, 1'b0, '0, stamp());

    // ---- random part: one register setting per phase, extremes first ----
    for (int p = 0; p < PHASES; p++) begin
      drain();
      calm  = (p % 3 == 2);
      quiet = (p == PHASES - 1);
      case (p)
        0: program_regs('0, '0, 1'b0);                        // empty mask, size clamps up
        1: program_regs('1, SAMP_W'(DEF_MAX_BLOCK_SAMPLES), 1'b1);
        2: program_regs(MASK_W'(1), '1, 1'b0);                // size clamps down
        3: program_regs(MASK_W'(16), SAMP_W'(1), 1'b1);
        default: program_regs(MASK_W'($urandom), SAMP_W'($urandom), 1'($urandom));
      endcase
      phase_end = sent + ITEMS_PER_PHASE;
      while (sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          run_session();
        end else begin
          noise_event();
        end
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("adc_block_acquisition_sequencer: match");
    end else begin
      $display("adc_block_acquisition_sequencer: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hdl/abs_pkg.sv
hdl/abs_if.sv
hdl/abs_core.sv
hdl/abs_out_queue.sv
hdl/adc_block_acquisition_sequencer.sv
test/abs_sequencer_checker.sv
test/adc_block_acquisition_sequencer_test.sv
